// ===== rtl/core/q2rm_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix: shared definitions
// Widths, entry indexes, divider pipeline depth and the sideband tag type.
// ----------------------------------------------------------------------------
package q2rm_pkg;

    localparam int COMP_W      = 16;  // one quaternion component, Q2.14
    localparam int ENT_W       = 16;  // one matrix entry, Q2.14
    localparam int NUM_ENTRIES = 9;
    localparam int PROD_W      = 2 * COMP_W;       // one product, Q4.28
    localparam int NUM_W       = PROD_W + 2;       // signed numerator incl. the factor two
    localparam int DEN_W       = PROD_W + 1;       // squared norm, unsigned
    localparam int REM_W       = DEN_W;            // partial remainder stays below the norm
    localparam int QUO_W       = ENT_W;            // unrounded quotient, one extra fraction bit

    // Two restoring steps per register stage of the divider.
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = QUO_W / DIV_STEPS_PER_STAGE;

    localparam logic signed [ENT_W-1:0] ONE_Q = ENT_W'(16384);

    // Row-major positions of the entries in the result.
    localparam int ENT_R1C1 = 0;
    localparam int ENT_R1C2 = 1;
    localparam int ENT_R1C3 = 2;
    localparam int ENT_R2C1 = 3;
    localparam int ENT_R2C2 = 4;
    localparam int ENT_R2C3 = 5;
    localparam int ENT_R3C1 = 6;
    localparam int ENT_R3C2 = 7;
    localparam int ENT_R3C3 = 8;

    // Sideband that rides along the divider: sign of each numerator and
    // the zero-norm flag.
    typedef struct packed {
        logic [NUM_ENTRIES-1:0] neg;
        logic                   deg;
    } q2rm_tag_t;

endpackage

// ===== rtl/core/q2rm_div_pipe.sv =====
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix: pipelined divider bank
// Nine restoring dividers sharing one denominator, two quotient bits per stage.
// ----------------------------------------------------------------------------
module q2rm_div_pipe (
    input  logic                                                   aclk,
    input  logic                                                   aresetn,
    input  logic                                                   en,
    input  logic                                                   in_valid,
    input  logic [q2rm_pkg::DEN_W-1:0]                             in_den,
    input  logic [q2rm_pkg::NUM_ENTRIES-1:0][q2rm_pkg::REM_W-1:0]  in_rem,
    input  q2rm_pkg::q2rm_tag_t                                    in_tag,
    output logic                                                   out_valid,
    output logic [q2rm_pkg::NUM_ENTRIES-1:0][q2rm_pkg::QUO_W-1:0]  out_quo,
    output q2rm_pkg::q2rm_tag_t                                    out_tag
);
    import q2rm_pkg::*;

    logic [DIV_STAGES-1:0]                                valid_reg;
    logic [DIV_STAGES-1:0][DEN_W-1:0]                     den_reg;
    logic [DIV_STAGES-1:0][NUM_ENTRIES-1:0][REM_W-1:0]    rem_reg;
    logic [DIV_STAGES-1:0][NUM_ENTRIES-1:0][QUO_W-1:0]    quo_reg;
    q2rm_tag_t                                            tag_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic                                  valid_src;
        logic [DEN_W-1:0]                      den_src;
        logic [NUM_ENTRIES-1:0][REM_W-1:0]     rem_src;
        logic [NUM_ENTRIES-1:0][QUO_W-1:0]     quo_src;
        q2rm_tag_t                             tag_src;
        logic [NUM_ENTRIES-1:0][REM_W-1:0]     rem_next;
        logic [NUM_ENTRIES-1:0][QUO_W-1:0]     quo_next;

        if (s == 0) begin : g_first
            assign valid_src = in_valid;
            assign den_src   = in_den;
            assign rem_src   = in_rem;
            assign quo_src   = '0;
            assign tag_src   = in_tag;
        end else begin : g_later
            assign valid_src = valid_reg[s-1];
            assign den_src   = den_reg[s-1];
            assign rem_src   = rem_reg[s-1];
            assign quo_src   = quo_reg[s-1];
            assign tag_src   = tag_reg[s-1];
        end

        // The very first step weighs the integer bit, so the remainder is
        // compared unshifted; every later step shifts it left once.
        always_comb begin
            logic [REM_W:0]   wide;
            logic [REM_W-1:0] r;
            logic [QUO_W-1:0] q;
            rem_next = '0;
            quo_next = '0;
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                r = rem_src[e];
                q = quo_src[e];
                for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
                    if (s == 0 && j == 0) begin
                        wide = {1'b0, r};
                    end else begin
                        wide = {r, 1'b0};
                    end
                    if (wide >= (REM_W+1)'(den_src)) begin
                        wide = wide - (REM_W+1)'(den_src);
                        q    = {q[QUO_W-2:0], 1'b1};
                    end else begin
                        q    = {q[QUO_W-2:0], 1'b0};
                    end
                    r = wide[REM_W-1:0];
                end
                rem_next[e] = r;
                quo_next[e] = q;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= valid_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[s] <= den_src;
                rem_reg[s] <= rem_next;
                quo_reg[s] <= quo_next;
                tag_reg[s] <= tag_src;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_quo   = quo_reg[DIV_STAGES-1];
    assign out_tag   = tag_reg[DIV_STAGES-1];

endmodule

// ===== rtl/core/quaternion_to_rotation_matrix_unit.sv =====
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix unit
// Converts a Q2.14 quaternion per unstalled cycle to its 3x3 rotation matrix.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata                              tuser
//  s_axis    in         x, y, z, w (16 bits each)          none
//  m_axis    out        nine entries, row-major, 16 each    degenerate
//
//  The pipeline is a product stage, a sum stage, eight divider stages and
//  the rounding stage that drives the output register. One transaction is
//  accepted every cycle unless the output stalls; the nine-lane restoring
//  divider bank retires two quotient bits per stage and never loops.
//  When the output holds a result that is not taken, the whole pipeline
//  freezes and s_axis_tready drops in the same cycle.
//  Reset clears the valid bits only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w
    input  logic [4*q2rm_pkg::COMP_W-1:0]                 s_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // m_row1_col1, m_row1_col2, ... m_row3_col3 (row-major)
    output logic [q2rm_pkg::NUM_ENTRIES*q2rm_pkg::ENT_W-1:0] m_axis_tdata,
    // degenerate
    output logic [0:0]                                    m_axis_tuser
);
    import q2rm_pkg::*;

    logic pipe_en;

    // Product stage.
    logic                     valid_a_reg;
    logic signed [PROD_W-1:0] sx_a_reg, sy_a_reg, sz_a_reg, sw_a_reg;
    logic signed [PROD_W-1:0] xy_a_reg, zw_a_reg, xz_a_reg, yw_a_reg, yz_a_reg, xw_a_reg;

    // Sum stage.
    logic                                valid_b_reg;
    logic [DEN_W-1:0]                    den_b_reg, den_b_next;
    logic [NUM_ENTRIES-1:0][REM_W-1:0]   mag_b_reg, mag_b_next;
    q2rm_tag_t                           tag_b_reg, tag_b_next;

    // Divider outputs.
    logic                                div_valid;
    logic [NUM_ENTRIES-1:0][QUO_W-1:0]   div_quo;
    q2rm_tag_t                           div_tag;

    // Output register.
    logic                                m_valid_reg;
    logic [NUM_ENTRIES-1:0][ENT_W-1:0]   ent_reg, ent_next;
    logic                                deg_reg;

    assign pipe_en = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            valid_a_reg <= s_axis_tvalid;
            valid_b_reg <= valid_a_reg;
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sx_a_reg <= PROD_W'($signed(s_axis_tdata[15:0]))
                      * PROD_W'($signed(s_axis_tdata[15:0]));
            sy_a_reg <= PROD_W'($signed(s_axis_tdata[31:16]))
                      * PROD_W'($signed(s_axis_tdata[31:16]));
            sz_a_reg <= PROD_W'($signed(s_axis_tdata[47:32]))
                      * PROD_W'($signed(s_axis_tdata[47:32]));
            sw_a_reg <= PROD_W'($signed(s_axis_tdata[63:48]))
                      * PROD_W'($signed(s_axis_tdata[63:48]));
            xy_a_reg <= PROD_W'($signed(s_axis_tdata[15:0]))
                      * PROD_W'($signed(s_axis_tdata[31:16]));
            zw_a_reg <= PROD_W'($signed(s_axis_tdata[47:32]))
                      * PROD_W'($signed(s_axis_tdata[63:48]));
            xz_a_reg <= PROD_W'($signed(s_axis_tdata[15:0]))
                      * PROD_W'($signed(s_axis_tdata[47:32]));
            yw_a_reg <= PROD_W'($signed(s_axis_tdata[31:16]))
                      * PROD_W'($signed(s_axis_tdata[63:48]));
            yz_a_reg <= PROD_W'($signed(s_axis_tdata[31:16]))
                      * PROD_W'($signed(s_axis_tdata[47:32]));
            xw_a_reg <= PROD_W'($signed(s_axis_tdata[15:0]))
                      * PROD_W'($signed(s_axis_tdata[63:48]));
        end
    end

    // Numerators are split into sign and magnitude for the divider.
    always_comb begin
        logic signed [NUM_W-1:0] sx, sy, sz, sw;
        logic signed [NUM_W-1:0] num [NUM_ENTRIES];
        logic signed [NUM_W-1:0] norm;
        logic signed [NUM_W-1:0] absval;
        sx = NUM_W'(sx_a_reg);
        sy = NUM_W'(sy_a_reg);
        sz = NUM_W'(sz_a_reg);
        sw = NUM_W'(sw_a_reg);
        norm = sx + sy + sz + sw;
        num[ENT_R1C1] = sx - sy - sz + sw;
        num[ENT_R2C2] = sy - sx - sz + sw;
        num[ENT_R3C3] = sz - sx - sy + sw;
        num[ENT_R2C1] = (NUM_W'(xy_a_reg) + NUM_W'(zw_a_reg)) <<< 1;
        num[ENT_R1C2] = (NUM_W'(xy_a_reg) - NUM_W'(zw_a_reg)) <<< 1;
        num[ENT_R3C1] = (NUM_W'(xz_a_reg) - NUM_W'(yw_a_reg)) <<< 1;
        num[ENT_R1C3] = (NUM_W'(xz_a_reg) + NUM_W'(yw_a_reg)) <<< 1;
        num[ENT_R3C2] = (NUM_W'(yz_a_reg) + NUM_W'(xw_a_reg)) <<< 1;
        num[ENT_R2C3] = (NUM_W'(yz_a_reg) - NUM_W'(xw_a_reg)) <<< 1;
        den_b_next     = norm[DEN_W-1:0];
        tag_b_next.deg = (norm == '0);
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            tag_b_next.neg[e] = num[e][NUM_W-1];
            absval            = num[e][NUM_W-1] ? -num[e] : num[e];
            mag_b_next[e]     = absval[REM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            den_b_reg <= den_b_next;
            mag_b_reg <= mag_b_next;
            tag_b_reg <= tag_b_next;
        end
    end

    q2rm_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (valid_b_reg),
        .in_den    (den_b_reg),
        .in_rem    (mag_b_reg),
        .in_tag    (tag_b_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_tag   (div_tag)
    );

    // The quotient carries one extra fraction bit; adding one and dropping
    // it rounds half away from zero on the magnitude. The exact ratio never
    // exceeds one, so no clamp is reachable.
    always_comb begin
        logic [QUO_W:0]   rounded;
        logic [ENT_W-1:0] mag;
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            rounded = {1'b0, div_quo[e]} + (QUO_W+1)'(1);
            mag     = rounded[QUO_W:1];
            if (div_tag.deg) begin
                if (e == ENT_R1C1 || e == ENT_R2C2 || e == ENT_R3C3) begin
                    ent_next[e] = ONE_Q;
                end else begin
                    ent_next[e] = '0;
                end
            end else begin
                ent_next[e] = div_tag.neg[e] ? -mag : mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ent_reg <= ent_next;
            deg_reg <= div_tag.deg;
        end
    end

    assign s_axis_tready   = pipe_en;
    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = ent_reg;
    assign m_axis_tuser[0] = deg_reg;

    // Every entry of a rotation matrix lies within plus or minus one.
    logic all_in_range;
    always_comb begin
        all_in_range = 1'b1;
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            if ($signed(ent_reg[e]) > ONE_Q || $signed(ent_reg[e]) < -ONE_Q) begin
                all_in_range = 1'b0;
            end
        end
    end

    a_entry_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> all_in_range)
        else $error("matrix entry outside the unit range");

    a_identity_on_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && deg_reg) |->
            ($signed(ent_reg[ENT_R1C1]) == ONE_Q && $signed(ent_reg[ENT_R2C2]) == ONE_Q &&
             $signed(ent_reg[ENT_R3C3]) == ONE_Q && ent_reg[ENT_R1C2] == '0 &&
             ent_reg[ENT_R2C1] == '0 && ent_reg[ENT_R3C1] == '0 &&
             ent_reg[ENT_R1C3] == '0 && ent_reg[ENT_R2C3] == '0 &&
             ent_reg[ENT_R3C2] == '0))
        else $error("zero-norm result is not the identity");

    a_output_follows_divider: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_en |=> (m_valid_reg == $past(div_valid)))
        else $error("output valid lost or invented a transaction");

    a_freeze_holds_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> ($stable(ent_reg) && $stable(deg_reg) && m_valid_reg))
        else $error("stalled result changed");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the quaternion to rotation matrix unit
// Streams directed and random quaternions into the unit and checks each
// matrix it returns against an in-line integer model of the conversion.
// Both channels stall at random, except for a quiet stretch mid-run.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import q2rm_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int IDLE_PCT     = 17;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic [NUM_ENTRIES*ENT_W-1:0] ents;
        logic                         deg;
    } rot_mat_t;

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // quat_x, quat_y, quat_z, quat_w
    logic [4*COMP_W-1:0]             s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // m_row1_col1 ... m_row3_col3, row-major
    logic [NUM_ENTRIES*ENT_W-1:0]    m_axis_tdata;
    // degenerate
    logic [0:0]                      m_axis_tuser;

    logic [4*COMP_W-1:0] quat_pending[$];
    rot_mat_t            matrix_due[$];
    int unsigned         fail_count   = 0;
    int unsigned         results_seen = 0;

    quaternion_to_rotation_matrix_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // round(num * 2^14 / den) with ties away from zero, clamped to 16 bits.
    function automatic logic signed [ENT_W-1:0] q14_quotient(longint num, longint den);
        longint mag;
        longint quo;
        mag = (num < 0) ? -num : num;
        quo = ((mag <<< 15) + den) / (2 * den);
        if (num < 0)
            quo = -quo;
        if (quo > 32767)
            quo = 32767;
        if (quo < -32768)
            quo = -32768;
        return quo[ENT_W-1:0];
    endfunction

    function automatic rot_mat_t rotation_of(logic [4*COMP_W-1:0] q);
        rot_mat_t res;
        longint   x, y, z, w;
        longint   sx, sy, sz, sw, norm;
        longint   num[NUM_ENTRIES];
        x    = longint'($signed(q[0*COMP_W +: COMP_W]));
        y    = longint'($signed(q[1*COMP_W +: COMP_W]));
        z    = longint'($signed(q[2*COMP_W +: COMP_W]));
        w    = longint'($signed(q[3*COMP_W +: COMP_W]));
        sx   = x * x;
        sy   = y * y;
        sz   = z * z;
        sw   = w * w;
        norm = sx + sy + sz + sw;
        res  = '0;
        if (norm == 0) begin
            res.ents[ENT_R1C1*ENT_W +: ENT_W] = ONE_Q;
            res.ents[ENT_R2C2*ENT_W +: ENT_W] = ONE_Q;
            res.ents[ENT_R3C3*ENT_W +: ENT_W] = ONE_Q;
            res.deg = 1'b1;
        end else begin
            num[ENT_R1C1] = sx - sy - sz + sw;
            num[ENT_R2C2] = -sx + sy - sz + sw;
            num[ENT_R3C3] = -sx - sy + sz + sw;
            num[ENT_R2C1] = 2 * (x * y + z * w);
            num[ENT_R1C2] = 2 * (x * y - z * w);
            num[ENT_R3C1] = 2 * (x * z - y * w);
            num[ENT_R1C3] = 2 * (x * z + y * w);
            num[ENT_R3C2] = 2 * (y * z + x * w);
            num[ENT_R2C3] = 2 * (y * z - x * w);
            for (int k = 0; k < NUM_ENTRIES; k++)
                res.ents[k*ENT_W +: ENT_W] = q14_quotient(num[k], norm);
        end
        return res;
    endfunction

    function automatic logic [4*COMP_W-1:0] pack_quat(logic [COMP_W-1:0] x,
                                                      logic [COMP_W-1:0] y,
                                                      logic [COMP_W-1:0] z,
                                                      logic [COMP_W-1:0] w);
        return {w, z, y, x};
    endfunction

    function automatic logic [COMP_W-1:0] corner_value();
        logic [COMP_W-1:0] pick[8];
        pick = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000,
                 16'h0001, 16'h7FFF, 16'h4000, 16'hC000};
        return pick[$urandom_range(7)];
    endfunction

    function automatic logic [COMP_W-1:0] span_value(int lim);
        int v;
        v = int'($urandom_range(2 * lim)) - lim;
        return v[COMP_W-1:0];
    endfunction

    // Stalls are suspended for a stretch of results in the middle of the run.
    function automatic bit take_break();
        if (results_seen >= 400 && results_seen < 700)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    always @(posedge aclk) begin : driver
        logic [4*COMP_W-1:0] next_quat;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (quat_pending.size() > 0 && !take_break()) begin
                next_quat = quat_pending.pop_front();
                s_axis_tdata  <= next_quat;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= aresetn && !take_break();
    end

    // Both channels are sampled here, so an expectation is always queued
    // before a result of the same edge is checked.
    always @(posedge aclk) begin : monitor
        rot_mat_t want;
        logic [ENT_W-1:0] got_ent;
        logic [ENT_W-1:0] want_ent;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                matrix_due.push_back(rotation_of(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (matrix_due.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, got %h / %b",
                             $time, m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end else begin
                    want = matrix_due.pop_front();
                    for (int k = 0; k < NUM_ENTRIES; k++) begin
                        got_ent  = m_axis_tdata[k*ENT_W +: ENT_W];
                        want_ent = want.ents[k*ENT_W +: ENT_W];
                        if (got_ent !== want_ent) begin
                            $display("%0t: row %0d col %0d expected %0d, got %0d",
                                     $time, k / 3 + 1, k % 3 + 1,
                                     $signed(want_ent), $signed(got_ent));
                            fail_count++;
                        end
                    end
                    if (m_axis_tuser[0] !== want.deg) begin
                        $display("%0t: degenerate expected %b, got %b",
                                 $time, want.deg, m_axis_tuser[0]);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int sel;
        // Zero quaternion, unit axes, extremes of every component, small values.
        quat_pending.push_back(pack_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        quat_pending.push_back(pack_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000));
        quat_pending.push_back(pack_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000));
        quat_pending.push_back(pack_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000));
        quat_pending.push_back(pack_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000));
        quat_pending.push_back(pack_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000));
        quat_pending.push_back(pack_quat(16'h0000, 16'h8000, 16'h0000, 16'h0000));
        quat_pending.push_back(pack_quat(16'h0000, 16'h0000, 16'h8000, 16'h0000));
        quat_pending.push_back(pack_quat(16'h0000, 16'h0000, 16'h0000, 16'h8000));
        quat_pending.push_back(pack_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        quat_pending.push_back(pack_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        quat_pending.push_back(pack_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        quat_pending.push_back(pack_quat(16'h8000, 16'h8000, 16'h0000, 16'h0000));
        quat_pending.push_back(pack_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000));
        quat_pending.push_back(pack_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000));
        quat_pending.push_back(pack_quat(16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
        quat_pending.push_back(pack_quat(16'h0001, 16'h0001, 16'h0000, 16'h0000));
        quat_pending.push_back(pack_quat(16'h0001, 16'h0001, 16'h0001, 16'h0001));
        quat_pending.push_back(pack_quat(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF));
        quat_pending.push_back(pack_quat(16'h0001, 16'h0002, 16'h0003, 16'h0004));
        quat_pending.push_back(pack_quat(16'h0000, 16'h0000, 16'h2D41, 16'h2D41));
        quat_pending.push_back(pack_quat(16'h2D41, 16'h0000, 16'h0000, 16'hD2BF));
        quat_pending.push_back(pack_quat(16'h0100, 16'h0000, 16'h0000, 16'h0000));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            sel = $urandom_range(99);
            if (sel < 35) begin
                quat_pending.push_back({$urandom, $urandom});
            end else if (sel < 60) begin
                quat_pending.push_back(pack_quat(span_value(16384), span_value(16384),
                                                 span_value(16384), span_value(16384)));
            end else if (sel < 75) begin
                quat_pending.push_back(pack_quat(span_value(3), span_value(3),
                                                 span_value(3), span_value(3)));
            end else if (sel < 85) begin
                // Random components with some of them forced to zero.
                quat_pending.push_back({$urandom, $urandom}
                                       & {{COMP_W{$urandom_range(1) == 1}},
                                          {COMP_W{$urandom_range(1) == 1}},
                                          {COMP_W{$urandom_range(1) == 1}},
                                          {COMP_W{$urandom_range(1) == 1}}});
            end else if (sel < 95) begin
                quat_pending.push_back(pack_quat(corner_value(), corner_value(),
                                                 corner_value(), corner_value()));
            end else begin
                quat_pending.push_back('0);
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Checked between rising edges so that the driver and monitor have
        // both settled for the cycle.
        while (quat_pending.size() != 0 || s_axis_tvalid || matrix_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
